FILE: rtl/core/bss_pkg.sv
// Shared types and constants of the boid separation steer block.
package bss_pkg;

   localparam int COORD_W     = 32;
   localparam int FAC_W       = 8;
   localparam int CMD_W       = 2;
   localparam int DIST_W      = 31;
   localparam int SUM_W       = 48;
   localparam int TERM_W      = SUM_W - 1;
   localparam int ACC_W       = 64;
   localparam int MUL_W       = 32;
   localparam int VMAG_W      = 48;
   localparam int RES_W       = 34;
   localparam int REQ_DATA_W  = 112;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 96;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD_POS  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_VEL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEIGHBOUR = 2'd2;

   localparam logic CSR_NEIGHBOUR_DIST = 1'b0;
   localparam logic CSR_MAX_SPEED      = 1'b1;

   localparam logic [DIST_W-1:0] NEIGHBOUR_DIST_RESET = 31'd655360;
   localparam logic [DIST_W-1:0] MAX_SPEED_RESET      = 31'd65536;

   localparam logic [TERM_W-1:0] TERM_CAP = '1;

   typedef enum logic [1:0] {
      KIND_POS,
      KIND_VEL,
      KIND_NEIGHBOUR
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic [FAC_W-1:0]           faction;
      logic                       active;
      logic                       last;
   } item_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_N_DIFF,
      ST_N_MUL,
      ST_N_ACC,
      ST_N_NDSQ,
      ST_N_CMP,
      ST_N_DIV,
      ST_N_DIVW,
      ST_N_END,
      ST_F_AVG,
      ST_F_AVGW,
      ST_F_CHK,
      ST_S_NORM,
      ST_S_MUL,
      ST_S_ACC,
      ST_S_SQRT,
      ST_S_OMUL,
      ST_S_ODIV,
      ST_S_ODIVW,
      ST_F_SUB,
      ST_F_CMUL,
      ST_F_CACC,
      ST_F_MSQ,
      ST_F_CCMP,
      ST_OUT
   } back_state_type;

endpackage

FILE: rtl/core/bss_front.sv
// Request decoder: unpacks and classifies requests and drops unknown commands.
module bss_front import bss_pkg::*; (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // x, y, z, faction, active, zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,   // command
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  q_push,
   output item_type              q_item
);

   logic known_cmd;

   always_comb begin
      q_item.x       = req_tdata[31:0];
      q_item.y       = req_tdata[63:32];
      q_item.z       = req_tdata[95:64];
      q_item.faction = req_tdata[103:96];
      q_item.active  = req_tdata[104];
      q_item.last    = req_tlast;
      known_cmd      = 1'b1;
      unique case (req_tuser)
         CMD_LOAD_POS:  q_item.kind = KIND_POS;
         CMD_LOAD_VEL:  q_item.kind = KIND_VEL;
         CMD_NEIGHBOUR: q_item.kind = KIND_NEIGHBOUR;
         default: begin
            q_item.kind = KIND_NEIGHBOUR;
            known_cmd   = 1'b0;
         end
      endcase
   end

   // drop unknown commands, but still take them off the bus
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && known_cmd;

endmodule

FILE: rtl/core/bss_queue.sv
// Short request queue between the decoder and the compute sequencer.
module bss_queue import bss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   assign pop_item = slot_ff[rd_ptr_ff];
   assign full     = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);

endmodule

FILE: rtl/core/bss_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
module bss_div #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quot
);

   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     quo_ff;
   logic [W-1:0]     den_ff;
   logic [W:0]       shifted;
   logic [W:0]       trial;
   logic             fits;
   logic [W-1:0]     rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      rem_in  = fits ? trial[W-1:0] : shifted[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: rtl/core/bss_back.sv
// Compute sequencer: reference state, neighbour accumulation and final steer.
module bss_back import bss_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_BOIDS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [DIST_W-1:0]     csr_wdata,
   input  logic                  q_empty,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int DIV_W = (31 + 2 * FRAC_BITS > 64) ? 31 + 2 * FRAC_BITS : 64;
   localparam int SHIFT = 2 * FRAC_BITS;
   localparam int HIT_W = $clog2(MAX_BOIDS + 1);

   back_state_type state_ff, state_in;

   logic signed [COORD_W-1:0] ref_pos_ff [3];
   logic signed [COORD_W-1:0] ref_vel_ff [3];
   logic [FAC_W-1:0]          ref_fac_ff;
   logic [DIST_W-1:0]         nd_ff;
   logic [DIST_W-1:0]         ms_ff;
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic [HIT_W-1:0]          hit_ff;
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;

   item_type                  cur_ff;
   logic [DIST_W-1:0]         dmag_ff [3];
   logic                      dneg_ff [3];
   logic [1:0]                idx_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [ACC_W-1:0]          prod_ff;
   logic [VMAG_W-1:0]         vmag_ff [3];
   logic                      vneg_ff [3];
   logic signed [RES_W-1:0]   res_ff [3];
   logic                      pass_ff;
   logic [ACC_W-1:0]          sq_v_ff;
   logic [ACC_W-1:0]          sq_res_ff;
   logic [ACC_W-1:0]          sq_bit_ff;
   logic [4:0]                sq_cnt_ff;

   logic signed [COORD_W:0]   diff_c [3];
   logic [COORD_W:0]          dmag_c [3];
   logic                      take_c;
   logic                      reject_c;
   logic [1:0]                idx_wrap;
   logic                      idx_last;
   logic [VMAG_W-1:0]         mx_c;
   logic signed [RES_W-1:0]   c_c [3];
   logic [RES_W-1:0]          cmag_c [3];
   logic                      over_c;
   logic [SUM_W-1:0]          avg_num_c;
   logic [TERM_W-1:0]         term_q;
   logic signed [SUM_W:0]     term_c;
   logic signed [SUM_W+1:0]   sum_wide;
   logic signed [SUM_W-1:0]   sum_sat;
   logic [ACC_W-1:0]          sq_try;
   logic [RES_W-1:0]          oq_c;
   logic                      vec_zero;
   logic                      out_free;

   logic [MUL_W-1:0]          mul_a;
   logic [MUL_W-1:0]          mul_b;
   logic                      div_start;
   logic [DIV_W-1:0]          div_num;
   logic [DIV_W-1:0]          div_den;
   logic                      div_done;
   logic [DIV_W-1:0]          div_quot;

   bss_div #(.W(DIV_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // datapath helpers
   always_comb begin
      take_c   = cur_ff.active && (cur_ff.faction != ref_fac_ff);
      reject_c = 1'b0;
      diff_c[0] = 33'(ref_pos_ff[0]) - 33'(cur_ff.x);
      diff_c[1] = 33'(ref_pos_ff[1]) - 33'(cur_ff.y);
      diff_c[2] = 33'(ref_pos_ff[2]) - 33'(cur_ff.z);
      for (int i = 0; i < 3; i++) begin
         dmag_c[i] = diff_c[i][COORD_W] ? 33'(-diff_c[i]) : 33'(diff_c[i]);
         if (dmag_c[i] >= {2'b00, nd_ff}) reject_c = 1'b1;
      end

      idx_last = (idx_ff == 2'd2);
      idx_wrap = idx_last ? 2'd0 : idx_ff + 2'd1;

      mx_c = vmag_ff[0];
      if (vmag_ff[1] > mx_c) mx_c = vmag_ff[1];
      if (vmag_ff[2] > mx_c) mx_c = vmag_ff[2];
      vec_zero = (vmag_ff[0] == '0) && (vmag_ff[1] == '0) && (vmag_ff[2] == '0);

      over_c = 1'b0;
      for (int i = 0; i < 3; i++) begin
         c_c[i]    = res_ff[i] - RES_W'(ref_vel_ff[i]);
         cmag_c[i] = c_c[i][RES_W-1] ? RES_W'(-c_c[i]) : RES_W'(c_c[i]);
         if (cmag_c[i] > {3'b000, ms_ff}) over_c = 1'b1;
      end

      avg_num_c = sum_ff[idx_ff][SUM_W-1] ? SUM_W'(-sum_ff[idx_ff])
                                          : SUM_W'(sum_ff[idx_ff]);

      // saturate each term at the sum range, then add with saturation
      term_q   = (|div_quot[DIV_W-1:TERM_W]) ? TERM_CAP : div_quot[TERM_W-1:0];
      term_c   = dneg_ff[idx_ff] ? -$signed({2'b00, term_q}) : $signed({2'b00, term_q});
      sum_wide = (SUM_W+2)'(sum_ff[idx_ff]) + (SUM_W+2)'(term_c);
      if (sum_wide[SUM_W+1:SUM_W-1] == 3'b000 || sum_wide[SUM_W+1:SUM_W-1] == 3'b111)
         sum_sat = sum_wide[SUM_W-1:0];
      else if (sum_wide[SUM_W+1])
         sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      else
         sum_sat = {1'b0, {(SUM_W-1){1'b1}}};

      sq_try = sq_res_ff + sq_bit_ff;
      oq_c   = vneg_ff[idx_ff] ? -RES_W'(div_quot[DIST_W-1:0])
                               : RES_W'(div_quot[DIST_W-1:0]);
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (!q_empty && q_item.kind == KIND_NEIGHBOUR) state_in = ST_N_DIFF;
         ST_N_DIFF:  state_in = (take_c && !reject_c) ? ST_N_MUL : ST_N_END;
         ST_N_MUL:   state_in = ST_N_ACC;
         ST_N_ACC:   state_in = idx_last ? ST_N_NDSQ : ST_N_MUL;
         ST_N_NDSQ:  state_in = ST_N_CMP;
         ST_N_CMP:   state_in = (acc_ff == '0 || acc_ff >= prod_ff) ? ST_N_END : ST_N_DIV;
         ST_N_DIV:   state_in = ST_N_DIVW;
         ST_N_DIVW:  if (div_done) state_in = idx_last ? ST_N_END : ST_N_DIV;
         ST_N_END:   state_in = cur_ff.last ? ST_F_AVG : ST_IDLE;
         ST_F_AVG: begin
            if (hit_ff != '0) state_in = ST_F_AVGW;
            else if (idx_last) state_in = ST_F_CHK;
         end
         ST_F_AVGW:  if (div_done) state_in = idx_last ? ST_F_CHK : ST_F_AVG;
         ST_F_CHK:   state_in = vec_zero ? ST_OUT : ST_S_NORM;
         ST_S_NORM: begin
            if (mx_c == '0) state_in = pass_ff ? ST_OUT : ST_F_SUB;
            else if (mx_c[VMAG_W-1:31] == '0 && mx_c[30]) state_in = ST_S_MUL;
         end
         ST_S_MUL:   state_in = ST_S_ACC;
         ST_S_ACC:   state_in = idx_last ? ST_S_SQRT : ST_S_MUL;
         ST_S_SQRT:  if (sq_cnt_ff == 5'd31) state_in = ST_S_OMUL;
         ST_S_OMUL:  state_in = ST_S_ODIV;
         ST_S_ODIV:  state_in = ST_S_ODIVW;
         ST_S_ODIVW: begin
            if (div_done) begin
               if (!idx_last) state_in = ST_S_OMUL;
               else state_in = pass_ff ? ST_OUT : ST_F_SUB;
            end
         end
         ST_F_SUB:   state_in = over_c ? ST_S_NORM : ST_F_CMUL;
         ST_F_CMUL:  state_in = ST_F_CACC;
         ST_F_CACC:  state_in = idx_last ? ST_F_MSQ : ST_F_CMUL;
         ST_F_MSQ:   state_in = ST_F_CCMP;
         ST_F_CCMP:  state_in = (acc_ff > prod_ff) ? ST_S_NORM : ST_OUT;
         ST_OUT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      q_pop     = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      unique case (state_ff)
         ST_IDLE: q_pop = !q_empty;
         ST_N_MUL: begin
            mul_a = MUL_W'(dmag_ff[idx_ff]);
            mul_b = MUL_W'(dmag_ff[idx_ff]);
         end
         ST_N_NDSQ: begin
            mul_a = MUL_W'(nd_ff);
            mul_b = MUL_W'(nd_ff);
         end
         ST_N_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(dmag_ff[idx_ff]) << SHIFT;
            div_den   = DIV_W'(acc_ff);
         end
         ST_F_AVG: begin
            div_start = (hit_ff != '0);
            div_num   = DIV_W'(avg_num_c);
            div_den   = DIV_W'(hit_ff);
         end
         ST_S_MUL, ST_F_CMUL: begin
            mul_a = MUL_W'(vmag_ff[idx_ff][30:0]);
            mul_b = MUL_W'(vmag_ff[idx_ff][30:0]);
         end
         ST_S_OMUL: begin
            mul_a = MUL_W'(vmag_ff[idx_ff][30:0]);
            mul_b = MUL_W'(ms_ff);
         end
         ST_S_ODIV: begin
            div_start = 1'b1;
            div_num   = DIV_W'(prod_ff);
            div_den   = DIV_W'(sq_res_ff);
         end
         ST_F_MSQ: begin
            mul_a = MUL_W'(ms_ff);
            mul_b = MUL_W'(ms_ff);
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ref_fac_ff   <= '0;
         hit_ff       <= '0;
         nd_ff        <= NEIGHBOUR_DIST_RESET;
         ms_ff        <= MAX_SPEED_RESET;
         for (int i = 0; i < 3; i++) begin
            ref_pos_ff[i] <= '0;
            ref_vel_ff[i] <= '0;
            sum_ff[i]     <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_NEIGHBOUR_DIST: nd_ff <= csr_wdata;
               CSR_MAX_SPEED:      ms_ff <= csr_wdata;
               default:            nd_ff <= nd_ff;
            endcase
         end
         if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (q_pop && q_item.kind == KIND_POS) begin
            ref_pos_ff[0] <= q_item.x;
            ref_pos_ff[1] <= q_item.y;
            ref_pos_ff[2] <= q_item.z;
            ref_fac_ff    <= q_item.faction;
         end
         if (q_pop && q_item.kind == KIND_VEL) begin
            ref_vel_ff[0] <= q_item.x;
            ref_vel_ff[1] <= q_item.y;
            ref_vel_ff[2] <= q_item.z;
         end
         if (state_ff == ST_N_DIVW && div_done) begin
            sum_ff[idx_ff] <= sum_sat;
            if (idx_last && hit_ff < HIT_W'(MAX_BOIDS)) hit_ff <= hit_ff + 1'b1;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            hit_ff       <= '0;
            for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cur_ff <= q_item;
            idx_ff <= 2'd0;
            acc_ff <= '0;
         end
         ST_N_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               dmag_ff[i] <= dmag_c[i][DIST_W-1:0];
               dneg_ff[i] <= diff_c[i][COORD_W];
            end
         end
         ST_N_ACC: begin
            acc_ff <= acc_ff + prod_ff;
            idx_ff <= idx_wrap;
         end
         ST_N_DIVW: if (div_done) idx_ff <= idx_wrap;
         ST_N_END:  idx_ff <= 2'd0;
         ST_F_AVG: begin
            if (hit_ff == '0) begin
               vmag_ff[idx_ff] <= '0;
               vneg_ff[idx_ff] <= 1'b0;
               idx_ff          <= idx_wrap;
            end
         end
         ST_F_AVGW: begin
            if (div_done) begin
               vmag_ff[idx_ff] <= div_quot[VMAG_W-1:0];
               vneg_ff[idx_ff] <= sum_ff[idx_ff][SUM_W-1];
               idx_ff          <= idx_wrap;
            end
         end
         ST_F_CHK: begin
            pass_ff <= 1'b0;
            for (int i = 0; i < 3; i++) res_ff[i] <= '0;
         end
         ST_S_NORM: begin
            // bring the largest magnitude into [2^30, 2^31)
            idx_ff <= 2'd0;
            acc_ff <= '0;
            if (mx_c == '0) begin
               for (int i = 0; i < 3; i++) res_ff[i] <= '0;
            end else if (mx_c[VMAG_W-1:31] != '0) begin
               for (int i = 0; i < 3; i++) vmag_ff[i] <= vmag_ff[i] >> 1;
            end else if (!mx_c[30]) begin
               for (int i = 0; i < 3; i++) vmag_ff[i] <= vmag_ff[i] << 1;
            end
         end
         ST_S_ACC: begin
            acc_ff <= acc_ff + prod_ff;
            idx_ff <= idx_wrap;
            if (idx_last) begin
               sq_v_ff   <= acc_ff + prod_ff;
               sq_res_ff <= '0;
               sq_bit_ff <= 64'd1 << 62;
               sq_cnt_ff <= '0;
            end
         end
         ST_S_SQRT: begin
            if (sq_v_ff >= sq_try) begin
               sq_v_ff   <= sq_v_ff - sq_try;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
         end
         ST_S_ODIVW: begin
            if (div_done) begin
               res_ff[idx_ff] <= oq_c;
               idx_ff         <= idx_wrap;
            end
         end
         ST_F_SUB: begin
            pass_ff <= 1'b1;
            idx_ff  <= 2'd0;
            acc_ff  <= '0;
            for (int i = 0; i < 3; i++) begin
               res_ff[i]  <= c_c[i];
               vmag_ff[i] <= VMAG_W'(cmag_c[i]);
               vneg_ff[i] <= c_c[i][RES_W-1];
            end
         end
         ST_F_CACC: begin
            acc_ff <= acc_ff + prod_ff;
            idx_ff <= idx_wrap;
         end
         ST_OUT: begin
            if (out_free)
               rsp_data_ff <= {res_ff[2][COORD_W-1:0], res_ff[1][COORD_W-1:0],
                               res_ff[0][COORD_W-1:0]};
         end
         default: begin
            cur_ff <= cur_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/boid_separation_steer.sv
// Separation steering for one reference boid over a stream of neighbour boids.
//
// Requests enter a two-deep queue and are worked one at a time. A neighbour
// that is inactive, of the same faction or out of range on one axis is dropped
// first, one that only the squared distance rejects is dropped after that test,
// and a hit takes three divisions on the shared one-bit-per-cycle divider,
// whose width is DIV_W = max(31 + 2 * FRAC_BITS, 64). The request marked last
// then adds the averaging (three divisions, skipped with no hits) and up to two
// length scalings, each a normalizing shift, a square root and three divisions.
// The divider and one 32 x 32 multiplier are shared by all steps. No clearing
// pass is needed after reset.
module boid_separation_steer import bss_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_BOIDS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // x, y, z, faction, active, zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,   // command
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // steer_x, steer_y, steer_z
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [DIST_W-1:0]     csr_wdata
);

   logic     q_full;
   logic     q_empty;
   logic     q_push;
   logic     q_pop;
   item_type q_in_item;
   item_type q_out_item;

   bss_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   bss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   bss_back #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_BOIDS (MAX_BOIDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_empty    (q_empty),
      .q_item     (q_out_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue pushed while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

FILE: dv/tb.sv
// Self-checking testbench of the boid separation steer block.
module tb;
   import bss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 16;
   localparam int MAX_BOIDS = 1024;
   localparam longint TIMEOUT_CYCLES = 10_000_000;
   localparam int SETTLE_CYCLES = 1200;
   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [DIST_W-1:0] REG_MAX = '1;

   typedef longint vec3_type [3];

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // x, y, z, faction, active, zero pad
   logic [REQ_USER_W-1:0] req_tuser;   // command
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // steer_x, steer_y, steer_z
   logic                  csr_we;
   logic                  csr_addr;
   logic [DIST_W-1:0]     csr_wdata;

   boid_separation_steer #(.FRAC_BITS(FRAC_BITS), .MAX_BOIDS(MAX_BOIDS)) i_dut (.*);

   // steering predictor state
   vec3_type       ref_pos, ref_vel, steer_acc;
   logic [FAC_W-1:0] ref_fac;
   int             hit_cnt;
   longint unsigned radius, top_speed;
   logic [RSP_DATA_W-1:0] steer_q[$];
   item_type       stim_q[$];

   int  n_fail, n_mismatch;
   int  stall_cycles;
   bit  quiet;   // no idling on either side

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      longint cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc > TIMEOUT_CYCLES) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------- predictor ----------------
   function automatic longint unsigned umag(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned div_frac(longint unsigned n, int s,
                                                 longint unsigned d, longint unsigned cap);
      longint unsigned q, r, b;
      q = n / d;
      r = n % d;
      if (q > cap) return cap;
      for (int i = 0; i < s; i++) begin
         b = (r >= d - r) ? 1 : 0;
         r = b ? r - (d - r) : r + r;
         if (q > (cap - b) / 2) return cap;
         q = 2 * q + b;
      end
      return q;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic vec3_type rescale(vec3_type v, longint unsigned len);
      longint unsigned m[3], mx, s, norm;
      vec3_type o;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = umag(v[i]);
         if (m[i] > mx) mx = m[i];
         o[i] = 0;
      end
      if (mx == 0) return o;
      while (mx >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      for (int i = 0; i < 3; i++) s += m[i] * m[i];
      norm = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'(m[i] * len / norm);
         if (v[i] < 0) o[i] = -o[i];
      end
      return o;
   endfunction

   function automatic void add_neighbour(vec3_type p);
      longint d[3], t, s;
      longint unsigned m[3], d2;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = ref_pos[i] - p[i];
         m[i] = umag(d[i]);
         if (m[i] >= radius) return;
      end
      for (int i = 0; i < 3; i++) d2 += m[i] * m[i];
      if (d2 == 0 || d2 >= radius * radius) return;
      for (int i = 0; i < 3; i++) begin
         t = longint'(div_frac(m[i], 2 * FRAC_BITS, d2, SUM_MAX));
         if (d[i] < 0) t = -t;
         s = steer_acc[i] + t;
         if (s > SUM_MAX) s = SUM_MAX;
         if (s < SUM_MIN) s = SUM_MIN;
         steer_acc[i] = s;
      end
      if (hit_cnt < MAX_BOIDS) hit_cnt++;
   endfunction

   function automatic vec3_type separation_steer();
      vec3_type avg, c, res;
      bit nz, over;
      longint unsigned s;
      nz = 0;
      over = 0;
      for (int i = 0; i < 3; i++) begin
         avg[i] = hit_cnt != 0 ? steer_acc[i] / longint'(hit_cnt) : 0;
         if (avg[i] != 0) nz = 1;
         res[i] = 0;
      end
      if (!nz) return res;
      c = rescale(avg, top_speed);
      for (int i = 0; i < 3; i++) begin
         c[i] -= ref_vel[i];
         if (umag(c[i]) > top_speed) over = 1;
      end
      if (!over) begin
         s = 0;
         for (int i = 0; i < 3; i++) s += umag(c[i]) * umag(c[i]);
         over = s > top_speed * top_speed;
      end
      return over ? rescale(c, top_speed) : c;
   endfunction

   function automatic void predict(item_type it);
      vec3_type v, r;
      v[0] = it.x;
      v[1] = it.y;
      v[2] = it.z;
      case (it.kind)
         KIND_POS: begin
            ref_pos = v;
            ref_fac = it.faction;
         end
         KIND_VEL: ref_vel = v;
         KIND_NEIGHBOUR: begin
            if (it.active && it.faction != ref_fac) add_neighbour(v);
            if (it.last) begin
               r = separation_steer();
               steer_q.push_back({r[2][31:0], r[1][31:0], r[0][31:0]});
               for (int i = 0; i < 3; i++) steer_acc[i] = 0;
               hit_cnt = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------- result check ----------------
   always @(posedge clock) begin
      logic [RSP_DATA_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (steer_q.size() == 0) begin
            n_fail++;
            if (n_mismatch++ < 10) $display("unexpected steer result %h", rsp_tdata);
         end else begin
            want = steer_q.pop_front();
            for (int f = 0; f < 3; f++) begin
               if (rsp_tdata[32*f +: 32] !== want[32*f +: 32]) begin
                  n_fail++;
                  if (n_mismatch++ < 10)
                     $display("steer[%0d] mismatch: expected %h actual %h",
                              f, want[32*f +: 32], rsp_tdata[32*f +: 32]);
               end
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles <= stall_cycles - 1;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= pick_gap() == 0;
      end
   end

   // ---------------- stimulus helpers ----------------
   function automatic item_type mk(kind_type k, longint x, longint y, longint z,
                                   int fac, int act, int lst);
      item_type it;
      it.kind = k;
      it.x = x[31:0];
      it.y = y[31:0];
      it.z = z[31:0];
      it.faction = fac[7:0];
      it.active = act[0];
      it.last = lst[0];
      return it;
   endfunction

   task automatic drive_requests();
      item_type it;
      int g;
      while (stim_q.size() != 0) begin
         it = stim_q.pop_front();
         g = pick_gap();
         if (g > 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= {7'b0, it.active, it.faction, it.z, it.y, it.x};
         req_tuser <= it.kind;
         req_tlast <= it.last;
         do @(posedge clock); while (!req_tready);
         predict(it);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (steer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [DIST_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_NEIGHBOUR_DIST) radius = val;
      else top_speed = val;
   endtask

   function automatic longint near(longint c, longint unsigned span);
      longint unsigned r;
      r = span > 64'h4000_0000 ? 64'h4000_0000 : span;
      if (r == 0) r = 1;
      return c + longint'({$urandom, $urandom} % (2 * r + 1)) - longint'(r);
   endfunction

   // one well-formed frame with random content
   task automatic queue_frame(int n);
      longint px, py, pz, vs;
      int fac;
      bit wild;
      wild = $urandom_range(0, 9) == 0;
      px = wild ? longint'(int'($urandom)) : near(0, 64'd1 << 24);
      py = wild ? longint'(int'($urandom)) : near(0, 64'd1 << 24);
      pz = wild ? longint'(int'($urandom)) : near(0, 64'd1 << 24);
      fac = $urandom_range(0, 255);
      stim_q.push_back(mk(KIND_POS, px, py, pz, fac, $urandom, $urandom));
      vs = $urandom_range(0, 3) == 0 ? 64'h8000_0000 : longint'(top_speed) * 2 + 1;
      stim_q.push_back(mk(KIND_VEL, near(0, vs), near(0, vs), near(0, vs),
                          $urandom, $urandom, $urandom));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0)
            stim_q.push_back(mk(kind_type'($urandom_range(0, 3)), int'($urandom),
                                int'($urandom), int'($urandom), $urandom, $urandom, 0));
         else
            stim_q.push_back(mk(KIND_NEIGHBOUR, near(px, radius), near(py, radius),
                                near(pz, radius),
                                $urandom_range(0, 3) == 0 ? fac : $urandom_range(0, 255),
                                $urandom_range(0, 9) != 0, 0));
      end
      stim_q.push_back(mk(KIND_NEIGHBOUR, near(px, radius), near(py, radius),
                          near(pz, radius), $urandom, $urandom_range(0, 4) != 0, 1));
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      longint one;
      one = 64'd1 << FRAC_BITS;
      stim_q.push_back(mk(KIND_POS, 0, 0, 0, 0, 0, 1));       // last ignored on load
      stim_q.push_back(mk(KIND_VEL, 0, 0, 0, 0, 0, 1));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 0, 0, 0, 1, 1, 1));  // zero distance: no hit
      stim_q.push_back(mk(KIND_NEIGHBOUR, one, 0, 0, 1, 1, 0));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 0, -2 * one, one, 255, 1, 0));
      stim_q.push_back(mk(KIND_NEIGHBOUR, one, one, 0, 0, 1, 0)); // same faction
      stim_q.push_back(mk(KIND_NEIGHBOUR, one, 0, one, 3, 0, 0)); // inactive
      stim_q.push_back(mk(kind_type'(CMD_UNKNOWN), one, one, one, 9, 1, 1));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 10 * one, 0, 0, 1, 1, 0)); // on the radius
      stim_q.push_back(mk(KIND_NEIGHBOUR, 1, 0, 0, 1, 1, 0));    // one lsb away
      stim_q.push_back(mk(KIND_NEIGHBOUR, 64'sh7FFF_FFFF, -64'sh8000_0000,
                          64'sh7FFF_FFFF, 1, 1, 0));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 0, 0, 0, 7, 0, 1));    // inactive last
      stim_q.push_back(mk(KIND_POS, 64'sh7FFF_FFFF, -64'sh8000_0000, 3, 255, 1, 0));
      stim_q.push_back(mk(KIND_VEL, -64'sh8000_0000, 64'sh7FFF_FFFF, -1, 255, 1, 0));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 64'sh7FFF_0000, -64'sh7FFF_0000, 0, 4, 1, 0));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 64'sh7FFF_FFFF, -64'sh8000_0000, 3, 4, 1, 1));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 5, 5, 5, 2, 1, 1));     // no hits
      stim_q.push_back(mk(KIND_VEL, 3 * one, -one, 0, 0, 0, 0));
      stim_q.push_back(mk(KIND_NEIGHBOUR, 64'sh7FFF_FFF0, -64'sh7FFF_FFF0, 1, 1, 1, 1));
      drive_requests();
      drain();
   endtask

   task automatic test_register_extremes();
      logic [DIST_W-1:0] nd[4] = '{31'd0, REG_MAX, 31'd1, 31'd200000};
      logic [DIST_W-1:0] ms[4] = '{REG_MAX, 31'd0, 31'd1, 31'd3000000};
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_NEIGHBOUR_DIST, nd[p]);
         write_reg(CSR_MAX_SPEED, ms[p]);
         repeat (3) queue_frame($urandom_range(1, 6));
         drive_requests();
         drain();
      end
   endtask

   // saturate the hit counter in one long frame
   task automatic test_count_full();
      write_reg(CSR_NEIGHBOUR_DIST, REG_MAX);
      write_reg(CSR_MAX_SPEED, 31'd65536);
      quiet = 1;
      stim_q.push_back(mk(KIND_POS, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < MAX_BOIDS + 12; i++)
         stim_q.push_back(mk(KIND_NEIGHBOUR, near(0, 64'd1 << 20), near(0, 64'd1 << 20),
                             near(0, 64'd1 << 20), 1, 1, i == MAX_BOIDS + 11));
      drive_requests();
      drain();
      quiet = 0;
   endtask

   task automatic test_output_hold_off();
      stall_cycles = 4000;
      repeat (6) queue_frame($urandom_range(0, 3));
      drive_requests();
      drain();
   endtask

   task automatic test_random_frames();
      int sent;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               write_reg(CSR_NEIGHBOUR_DIST, 31'd655360);
               write_reg(CSR_MAX_SPEED, 31'd65536);
            end
            1: begin
               write_reg(CSR_NEIGHBOUR_DIST, DIST_W'($urandom));
               write_reg(CSR_MAX_SPEED, DIST_W'($urandom));
            end
            2: begin
               write_reg(CSR_NEIGHBOUR_DIST, REG_MAX);
               write_reg(CSR_MAX_SPEED, REG_MAX);
            end
            default: begin
               write_reg(CSR_NEIGHBOUR_DIST, DIST_W'($urandom_range(1, 1 << 22)));
               write_reg(CSR_MAX_SPEED, DIST_W'($urandom_range(0, 1 << 20)));
            end
         endcase
         quiet = p == 2;
         sent = 0;
         while (sent < 220) begin
            queue_frame($urandom_range(0, 9));
            sent += stim_q.size();
            drive_requests();
         end
         drain();
      end
      quiet = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_addr = 1'b0;
      csr_wdata = '0;
      n_fail = 0;
      n_mismatch = 0;
      stall_cycles = 0;
      quiet = 0;
      for (int i = 0; i < 3; i++) begin
         ref_pos[i] = 0;
         ref_vel[i] = 0;
         steer_acc[i] = 0;
      end
      ref_fac = 0;
      hit_cnt = 0;
      radius = NEIGHBOUR_DIST_RESET;
      top_speed = MAX_SPEED_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_count_full();
      test_output_hold_off();
      test_random_frames();

      drain();
      if (n_fail == 0 && steer_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
